// ===== rtl/bel_pkg.sv =====
// Shared types, codes and keyword tables for the boolean expression lexer.
`default_nettype none

package bel_pkg;

   localparam int POS_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH      = 4;

   // result kinds
   localparam logic [3:0] KIND_LEFT    = 4'd0;
   localparam logic [3:0] KIND_RIGHT   = 4'd1;
   localparam logic [3:0] KIND_COMMA   = 4'd2;
   localparam logic [3:0] KIND_OR      = 4'd3;
   localparam logic [3:0] KIND_AND     = 4'd4;
   localparam logic [3:0] KIND_NOT     = 4'd5;
   localparam logic [3:0] KIND_SYMBOL  = 4'd6;
   localparam logic [3:0] KIND_LITCHAR = 4'd7;
   localparam logic [3:0] KIND_LITEND  = 4'd8;
   localparam logic [3:0] KIND_DONE    = 4'd9;
   localparam logic [3:0] KIND_ERROR   = 4'd10;

   localparam logic [7:0] CH_LEFT  = 8'h28;
   localparam logic [7:0] CH_RIGHT = 8'h29;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // keyword spellings, zero padded; row order gives the keyword select code
   localparam logic [7:0] KW_TEXT [0:3][0:7] = '{
      '{"O", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"A", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"N", "o", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"S", "y", "m", "b", "o", "l", 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN  [0:3] = '{3'd2, 3'd3, 3'd3, 3'd6};
   localparam logic [3:0] KW_KIND [0:3] = '{KIND_OR, KIND_AND, KIND_NOT, KIND_SYMBOL};

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  lit_char;
      logic [15:0] position;
      logic        final_res;
   } result_type;

   // one or two results caused by one input item
   typedef struct packed {
      logic       second;
      result_type res0;
      result_type res1;
   } entry_type;

   function automatic logic [15:0] sat_pos(input logic [31:0] pos);
      sat_pos = (pos > 32'h0000_FFFF) ? 16'hFFFF : pos[15:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/boolean_expression_lexer.sv =====
// Top level of the streaming boolean expression lexer.
//
// The req channel takes one text byte per item (req_ch) with req_end_of_text
// on the last byte of an expression. Whitespace is skipped. The rsp channel
// gives tokens, literal characters, literal ends, and a closing done or
// error result (rsp_final_res set). Each byte causes zero, one or two results.
//
// Throughput: one byte per cycle while the result side keeps up; the output
// register sends one result per cycle while the receiver is ready, so a byte
// with two results sends them in turn. Each result is queued, then registered.
// A four-entry queue between the lexer state and the output register absorbs
// bursts; req_ready drops only when that queue is full.
//
// Reset returns the lexer to idle with zero counts and empties the queue and
// output register. A stalled receiver holds the current result steady; the
// queue keeps filling until full, then the input stalls.
`default_nettype none

module boolean_expression_lexer #(
   parameter int POS_BITS = bel_pkg::POS_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_kind,
   output logic [7:0]  rsp_lit_char,
   output logic [15:0] rsp_position,
   output logic        rsp_final_res
);
   import bel_pkg::*;

   logic      take;
   logic      entry_valid;
   entry_type entry;
   logic      q_full, q_empty, q_pop;
   entry_type q_head;

   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;

   bel_front #(
      .POS_BITS(POS_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .ch          (req_ch),
      .end_of_text (req_end_of_text),
      .entry_valid (entry_valid),
      .entry       (entry)
   );

   bel_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (entry_valid),
      .push_entry (entry),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   bel_back u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (q_empty),
      .head          (q_head),
      .pop           (q_pop),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_lit_char  (rsp_lit_char),
      .rsp_position  (rsp_position),
      .rsp_final_res (rsp_final_res)
   );

endmodule

`default_nettype wire

// ===== rtl/bel_front.sv =====
// Lexer front end: tracks token state per text byte and builds result entries.
`default_nettype none

module bel_front #(
   parameter int POS_BITS = bel_pkg::POS_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         ch,
   input  logic               end_of_text,
   output logic               entry_valid,
   output bel_pkg::entry_type entry
);
   import bel_pkg::*;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'b0001,
      MODE_KEYWORD = 4'b0010,
      MODE_LITERAL = 4'b0100,
      MODE_ERROR   = 4'b1000
   } mode_type;

   mode_type            mode_ff, mode_in;
   logic [1:0]          sel_ff, sel_in;
   logic [2:0]          idx_ff, idx_in;
   logic [POS_BITS-1:0] start_ff, start_in;
   logic [POS_BITS-1:0] count_ff, count_in;

   logic       space;
   logic       err_now;
   logic       first_hit;
   logic [1:0] first_sel;
   logic [2:0] idx_next;
   logic       prim_v, close_v;
   result_type prim, close;

   always_comb begin
      first_hit = 1'b0;
      first_sel = 2'd0;
      for (int s = 3; s >= 0; s--) begin
         if (KW_TEXT[s][0] == ch) begin
            first_hit = 1'b1;
            first_sel = 2'(s);
         end
      end
   end

   assign space    = (ch >= CH_TAB && ch <= CH_CR) || ch == CH_SPACE;
   assign idx_next = idx_ff + 3'd1;

   always_comb begin
      mode_in  = mode_ff;
      sel_in   = sel_ff;
      idx_in   = idx_ff;
      start_in = start_ff;
      count_in = count_ff;
      err_now  = 1'b0;
      prim_v   = 1'b0;
      prim     = '0;
      close_v  = 1'b0;
      close    = '0;
      if (take) begin
         if (!space && mode_ff != MODE_ERROR) begin
            if (count_ff != '1) begin
               count_in = count_ff + 1'b1;
            end
            case (mode_ff)
               MODE_IDLE: begin
                  if (ch == CH_LEFT) begin
                     prim_v    = 1'b1;
                     prim.kind = KIND_LEFT;
                  end else if (ch == CH_RIGHT) begin
                     prim_v    = 1'b1;
                     prim.kind = KIND_RIGHT;
                  end else if (ch == CH_COMMA) begin
                     prim_v    = 1'b1;
                     prim.kind = KIND_COMMA;
                  end else if (ch == CH_QUOTE) begin
                     mode_in  = MODE_LITERAL;
                     start_in = count_ff;
                  end else if (first_hit) begin
                     mode_in  = MODE_KEYWORD;
                     sel_in   = first_sel;
                     idx_in   = 3'd1;
                     start_in = count_ff;
                  end else begin
                     mode_in  = MODE_ERROR;
                     start_in = count_ff;
                     err_now  = 1'b1;
                  end
               end
               MODE_KEYWORD: begin
                  if (ch == KW_TEXT[sel_ff][idx_ff] && ch != 8'h00) begin
                     if (idx_next >= KW_LEN[sel_ff]) begin
                        prim_v    = 1'b1;
                        prim.kind = KW_KIND[sel_ff];
                        mode_in   = MODE_IDLE;
                        idx_in    = 3'd0;
                     end else begin
                        idx_in = idx_next;
                     end
                  end else begin
                     mode_in = MODE_ERROR;
                     err_now = 1'b1;
                  end
               end
               MODE_LITERAL: begin
                  prim_v = 1'b1;
                  if (ch == CH_QUOTE) begin
                     prim.kind = KIND_LITEND;
                     mode_in   = MODE_IDLE;
                  end else begin
                     prim.kind     = KIND_LITCHAR;
                     prim.lit_char = ch;
                  end
               end
               default: ;
            endcase
            if (err_now) begin
               prim_v         = 1'b1;
               prim.kind      = KIND_ERROR;
               prim.position  = sat_pos(32'(start_in));
               prim.final_res = end_of_text;
            end
         end
         if (end_of_text) begin
            if (!err_now) begin
               close_v         = 1'b1;
               close.final_res = 1'b1;
               if (mode_in == MODE_IDLE) begin
                  close.kind = KIND_DONE;
               end else if (mode_in == MODE_LITERAL) begin
                  // unterminated literal reports the stripped text length
                  close.kind     = KIND_ERROR;
                  close.position = sat_pos(32'(count_in));
               end else begin
                  close.kind     = KIND_ERROR;
                  close.position = sat_pos(32'(start_in));
               end
            end
            mode_in  = MODE_IDLE;
            sel_in   = 2'd0;
            idx_in   = 3'd0;
            start_in = '0;
            count_in = '0;
         end
      end
   end

   always_comb begin
      entry_valid = prim_v || close_v;
      if (prim_v) begin
         entry.second = close_v;
         entry.res0   = prim;
         entry.res1   = close;
      end else begin
         entry.second = 1'b0;
         entry.res0   = close;
         entry.res1   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         sel_ff   <= 2'd0;
         idx_ff   <= 3'd0;
         start_ff <= '0;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         sel_ff   <= sel_in;
         idx_ff   <= idx_in;
         start_ff <= start_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bel_queue.sv =====
// Short FIFO of result entries between the lexer front end and the output stage.
`default_nettype none

module bel_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bel_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output bel_pkg::entry_type head
);
   import bel_pkg::*;

   localparam int DEPTH  = QUEUE_DEPTH;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   entry_type        slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bel_back.sv =====
// Output stage: splits queued entries into single results behind an output register.
`default_nettype none

module bel_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  bel_pkg::entry_type head,
   output logic               pop,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [3:0]         rsp_kind,
   output logic [7:0]         rsp_lit_char,
   output logic [15:0]        rsp_position,
   output logic               rsp_final_res
);
   import bel_pkg::*;

   logic       valid_ff, valid_in;
   logic       phase_ff, phase_in;
   result_type out_ff;
   logic       load;

   assign load = !empty && (!valid_ff || rsp_ready);
   // entry leaves the queue once its last result is loaded
   assign pop  = load && (phase_ff || !head.second);

   always_comb begin
      phase_in = phase_ff;
      valid_in = valid_ff;
      if (load) begin
         phase_in = !pop;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= phase_ff ? head.res1 : head.res0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_kind      = out_ff.kind;
   assign rsp_lit_char  = out_ff.lit_char;
   assign rsp_position  = out_ff.position;
   assign rsp_final_res = out_ff.final_res;

endmodule

`default_nettype wire

// ===== rtl/bel_checker.sv =====
// Port-level checks for the lexer, bound to the top level.
`default_nettype none

module bel_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_kind,
   input logic [7:0]  rsp_lit_char,
   input logic [15:0] rsp_position,
   input logic        rsp_final_res
);
   import bel_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_lit_char) && $stable(rsp_position) && $stable(rsp_final_res))
      else $error("rsp item changed while stalled");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ERROR |-> rsp_position == 16'd0)
      else $error("position set on a non-error item");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_LITCHAR |-> rsp_lit_char == 8'd0)
      else $error("lit_char set on a non-literal item");

   a_final_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_res |-> rsp_kind == KIND_DONE || rsp_kind == KIND_ERROR)
      else $error("final flag on an item that does not close the text");

endmodule

bind boolean_expression_lexer bel_checker u_bel_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_kind      (rsp_kind),
   .rsp_lit_char  (rsp_lit_char),
   .rsp_position  (rsp_position),
   .rsp_final_res (rsp_final_res)
);

`default_nettype wire

// ===== sim/lexer_token_checker.sv =====
// Watches the lexer's byte and token channels, predicts every token and compares it.
module lexer_token_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_text,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_kind,
   input  logic [7:0]  rsp_lit_char,
   input  logic [15:0] rsp_position,
   input  logic        rsp_final_res,
   output int          error_count,
   output int          backlog
);
   timeunit 1ns;
   timeprecision 1ps;
   import bel_pkg::*;

   localparam logic [15:0] POS_LIMIT  = 16'hFFFF;

   typedef enum logic [3:0] {
      LEX_IDLE    = 4'b0001,
      LEX_KEYWORD = 4'b0010,
      LEX_LITERAL = 4'b0100,
      LEX_FAILED  = 4'b1000
   } lex_state_type;

   lex_state_type lex_state;
   logic [1:0]    kw_sel;
   logic [2:0]    kw_pos;
   logic [15:0]   tok_start;
   logic [15:0]   text_len;
   result_type    pending_tokens[$];

   function automatic void push_token(input logic [3:0] kind, input logic [7:0] c,
                                      input logic [15:0] pos, input logic fin);
      result_type r;
      r.kind      = kind;
      r.lit_char  = c;
      r.position  = pos;
      r.final_res = fin;
      pending_tokens.insert(pending_tokens.size(), r);
   endfunction

   function automatic void clear_lexer();
      lex_state = LEX_IDLE;
      kw_sel    = 2'd0;
      kw_pos    = 3'd0;
      tok_start = 16'd0;
      text_len  = 16'd0;
   endfunction

   // one text byte in, zero to two tokens queued
   function automatic void lex_byte(input logic [7:0] c, input logic last);
      logic        blank;
      logic        err_now;
      logic        hit;
      logic [15:0] here;
      logic [2:0]  i;
      int          s;
      blank   = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
      err_now = 1'b0;
      if (!blank && lex_state != LEX_FAILED) begin
         here = text_len;
         if (text_len != POS_LIMIT) text_len = text_len + 16'd1;
         case (lex_state)
            LEX_IDLE: begin
               if (c == CH_LEFT) push_token(KIND_LEFT, 8'd0, 16'd0, 1'b0);
               else if (c == CH_RIGHT) push_token(KIND_RIGHT, 8'd0, 16'd0, 1'b0);
               else if (c == CH_COMMA) push_token(KIND_COMMA, 8'd0, 16'd0, 1'b0);
               else if (c == CH_QUOTE) begin
                  lex_state = LEX_LITERAL;
                  tok_start = here;
               end else begin
                  hit = 1'b0;
                  for (s = 0; s < 4; s++) begin
                     if (!hit && KW_TEXT[s][0] == c) begin
                        lex_state = LEX_KEYWORD;
                        kw_sel    = s[1:0];
                        kw_pos    = 3'd1;
                        tok_start = here;
                        hit       = 1'b1;
                     end
                  end
                  if (!hit) begin
                     lex_state = LEX_FAILED;
                     tok_start = here;
                     err_now   = 1'b1;
                  end
               end
            end
            LEX_KEYWORD: begin
               i = (kw_pos < 3'd6) ? kw_pos : 3'd6;
               if (KW_TEXT[kw_sel][i] == c && c != 8'd0) begin
                  kw_pos = i + 3'd1;
                  if (kw_pos >= KW_LEN[kw_sel]) begin
                     push_token(KW_KIND[kw_sel], 8'd0, 16'd0, 1'b0);
                     lex_state = LEX_IDLE;
                     kw_pos    = 3'd0;
                  end
               end else begin
                  lex_state = LEX_FAILED;
                  err_now   = 1'b1;
               end
            end
            default: begin
               if (c == CH_QUOTE) begin
                  push_token(KIND_LITEND, 8'd0, 16'd0, 1'b0);
                  lex_state = LEX_IDLE;
               end else begin
                  push_token(KIND_LITCHAR, c, 16'd0, 1'b0);
               end
            end
         endcase
         if (err_now) push_token(KIND_ERROR, 8'd0, tok_start, last);
      end
      if (last) begin
         // an error raised on this very byte already closes the text
         if (!err_now) begin
            case (lex_state)
               LEX_IDLE:    push_token(KIND_DONE, 8'd0, 16'd0, 1'b1);
               LEX_LITERAL: push_token(KIND_ERROR, 8'd0, text_len, 1'b1);
               default:     push_token(KIND_ERROR, 8'd0, tok_start, 1'b1);
            endcase
         end
         clear_lexer();
      end
   endfunction

   function automatic void check_field(input string what, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         clear_lexer();
         pending_tokens.delete();
         error_count = 0;
      end else begin
         if (req_valid && req_ready) lex_byte(req_ch, req_end_of_text);
         if (rsp_valid && rsp_ready) begin
            if (pending_tokens.size() == 0) begin
               error_count++;
               $display("%0t: unexpected token, expected none, got kind %0d", $time,
                        rsp_kind);
            end else begin
               want = pending_tokens.pop_front();
               check_field("kind", {12'd0, want.kind}, {12'd0, rsp_kind});
               check_field("lit_char", {8'd0, want.lit_char}, {8'd0, rsp_lit_char});
               check_field("position", want.position, rsp_position);
               check_field("final_res", {15'd0, want.final_res}, {15'd0, rsp_final_res});
            end
         end
      end
      backlog = pending_tokens.size();
   end

endmodule

// ===== sim/tb.sv =====
// Top of the lexer testbench: clock, reset, byte stimulus, stalls and the verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bel_pkg::*;

   localparam int STALL_LIMIT  = 5000;
   localparam int PHASE_ITEMS  = 400;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ch          = 8'd0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [3:0]  rsp_kind;
   logic [7:0]  rsp_lit_char;
   logic [15:0] rsp_position;
   logic        rsp_final_res;

   int         req_taken      = 0;
   int         idle_cycles    = 0;
   int         send_stall_pct = 0;
   int         recv_stall_pct = 0;
   int         items_sent     = 0;
   int         error_count;
   int         backlog;
   logic [7:0] text_q[$];

   boolean_expression_lexer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_lit_char    (rsp_lit_char),
      .rsp_position    (rsp_position),
      .rsp_final_res   (rsp_final_res)
   );

   lexer_token_checker token_chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_lit_char    (rsp_lit_char),
      .rsp_position    (rsp_position),
      .rsp_final_res   (rsp_final_res),
      .error_count     (error_count),
      .backlog         (backlog)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // handshake count for the driver, and a watchdog on cycles with no traffic
   always @(posedge clock) begin
      if (req_valid && req_ready) req_taken <= req_taken + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [7:0] blank_byte();
      if ($urandom_range(5) == 0) return CH_SPACE;
      return CH_TAB + 8'($urandom_range(4));
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      text_q = {text_q, b};
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      int seen;
      while ($urandom_range(99) < send_stall_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_ch          <= b;
      req_end_of_text <= last;
      seen = req_taken;
      do @(negedge clock); while (req_taken == seen);
   endtask

   task automatic send_text();
      for (int k = 0; k < text_q.size(); k++) begin
         send_byte(text_q[k], k == text_q.size() - 1);
         items_sent++;
      end
   endtask

   task automatic send_string(input string s);
      text_q.delete();
      for (int k = 0; k < s.len(); k++) add_byte(s[k]);
      send_text();
   endtask

   // hold the input low until every predicted token has come out
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (backlog != 0);
   endtask

   // mostly well-formed expressions with random content, some broken, some noise
   task automatic build_text();
      int         pick;
      int         len;
      int         sel;
      int         k;
      logic [7:0] b;
      text_q.delete();
      pick = $urandom_range(99);
      if (pick < 8) begin
         len = $urandom_range(1, 8);
         repeat (len) add_byte(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(3) == 0) add_byte(blank_byte());
            case ($urandom_range(7))
               0: add_byte(CH_LEFT);
               1: add_byte(CH_RIGHT);
               2: add_byte(CH_COMMA);
               3, 4: begin
                  sel = $urandom_range(3);
                  for (k = 0; k < KW_LEN[sel]; k++) begin
                     add_byte(KW_TEXT[sel][k]);
                     if ($urandom_range(9) == 0) add_byte(blank_byte());
                  end
               end
               default: begin
                  add_byte(CH_QUOTE);
                  len = $urandom_range(0, 5);
                  repeat (len) begin
                     b = 8'($urandom_range(255));
                     if (b == CH_QUOTE) b = CH_SPACE;
                     add_byte(b);
                  end
                  add_byte(CH_QUOTE);
               end
            endcase
         end
         if ($urandom_range(3) == 0) add_byte(blank_byte());
         if (pick >= 80) begin
            k = $urandom_range(text_q.size() - 1);
            if ($urandom_range(1)) text_q[k] = 8'($urandom_range(255));
            else text_q = text_q[0:k];
         end
      end
   endtask

   task automatic random_texts(input int target);
      items_sent = 0;
      while (items_sent < target) begin
         build_text();
         send_text();
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      send_stall_pct = 6;
      recv_stall_pct = 88;
      send_string("(A nd,Or)");
      send_string("Symbol''");
      send_string("x");
      send_string(" ");
      text_q.delete();
      add_byte(CH_QUOTE);
      add_byte(8'hFF);
      add_byte(8'h00);
      send_text();
      send_string("Nx(");
      random_texts(PHASE_ITEMS);
      drain();

      send_stall_pct = 88;
      recv_stall_pct = 6;
      random_texts(PHASE_ITEMS);
      drain();

      send_stall_pct = 0;
      recv_stall_pct = 0;
      random_texts(PHASE_ITEMS);
      drain();

      repeat (16) @(negedge clock);
      if (error_count == 0 && backlog == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
